// ===== hdl/lrs_pkg.sv =====
// Shared types and constants for the life automaton row stepper.
`timescale 1ns / 1ps

package lrs_pkg;

    // Width of every row mask on the ports.
    localparam int ROW_W = 64;

    // Width of the active column count register.
    localparam int COLCNT_W = 7;

    // Reset value of the active column count.
    localparam logic [COLCNT_W-1:0] COLCNT_RESET = 7'd64;

    // Neighbor count width: eight neighbors need four bits.
    localparam int NCNT_W = 4;

    // Neighbor counts of the B3/S23 rule.
    localparam logic [NCNT_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [NCNT_W-1:0] STAY_COUNT  = 4'd2;

    typedef logic [ROW_W-1:0] row_t;

endpackage

// ===== hdl/lrs_rule.sv =====
// Per-column next-generation logic for one grid row.
`timescale 1ns / 1ps

module lrs_rule #(
    parameter int COLS = 64
) (
    input  logic [COLS-1:0] up,
    input  logic [COLS-1:0] mid,
    input  logic [COLS-1:0] sup,
    input  logic [COLS-1:0] low,
    output logic [COLS-1:0] nxt_alive,
    output logic [COLS-1:0] nxt_super,
    output logic [COLS-1:0] corrupt
);

    // Zero padding on both sides stands for the dead cells beyond the edges.
    logic [COLS+1:0] up_pad;
    logic [COLS+1:0] mid_pad;
    logic [COLS+1:0] low_pad;

    assign up_pad  = {1'b0, up, 1'b0};
    assign mid_pad = {1'b0, mid, 1'b0};
    assign low_pad = {1'b0, low, 1'b0};

    for (genvar c = 0; c < COLS; c++) begin : g_lane
        logic [lrs_pkg::NCNT_W-1:0] ncnt;
        logic                       keep;

        always_comb
        begin
            ncnt = lrs_pkg::NCNT_W'(up_pad[c])  + lrs_pkg::NCNT_W'(up_pad[c+1])
                 + lrs_pkg::NCNT_W'(up_pad[c+2]) + lrs_pkg::NCNT_W'(mid_pad[c])
                 + lrs_pkg::NCNT_W'(mid_pad[c+2]) + lrs_pkg::NCNT_W'(low_pad[c])
                 + lrs_pkg::NCNT_W'(low_pad[c+1]) + lrs_pkg::NCNT_W'(low_pad[c+2]);
            keep = (ncnt == lrs_pkg::STAY_COUNT) || (ncnt == lrs_pkg::BIRTH_COUNT);
            if (mid[c])
            begin
                // A super cell that would die stays alive but loses super.
                nxt_alive[c] = keep | sup[c];
                nxt_super[c] = keep & sup[c];
            end
            else
            begin
                nxt_alive[c] = (ncnt == lrs_pkg::BIRTH_COUNT);
                nxt_super[c] = 1'b0;
            end
        end
    end

    assign corrupt = ~mid & sup;

endmodule

// ===== hdl/life_automaton_row_step.sv =====
// Top level of the life automaton row stepper (B3/S23 with super cells).
`timescale 1ns / 1ps

// Channel   Signals                                        Direction
// input     in_valid, in_stall, alive_row, super_row,      in (in_stall out)
//           final_row
// output    out_valid, out_stall, next_alive, next_super,  out (out_stall in)
//           corrupt_mask, grid_done
// config    cfg_write_en, cfg_write_data                   in
//
// An accepted row is registered in the input register; the result that it
// completes is written from there to the output register. One row is taken
// per cycle unless the output register is stalled or a bottom row that closes
// a running window takes its second step; such a row yields two results. Reset
// empties the window and sets the active column count to 64. A stalled output
// holds its transaction while the input register absorbs one more row.

module life_automaton_row_step #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lrs_pkg::ROW_W-1:0]    alive_row,
    input  logic [lrs_pkg::ROW_W-1:0]    super_row,
    input  logic                         final_row,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lrs_pkg::ROW_W-1:0]    next_alive,
    output logic [lrs_pkg::ROW_W-1:0]    next_super,
    output logic [lrs_pkg::ROW_W-1:0]    corrupt_mask,
    output logic                         grid_done,
    input  logic                         cfg_write_en,
    input  logic [lrs_pkg::COLCNT_W-1:0] cfg_write_data
);

    // Configuration register.
    logic [lrs_pkg::COLCNT_W-1:0] active_columns_reg;

    // Input register.
    logic             in_valid_reg;
    lrs_pkg::row_t    alive_reg;
    lrs_pkg::row_t    super_reg;
    logic             final_reg;

    // Row window: the row above and the row being completed.
    logic                   held_reg;
    logic                   held_next;
    logic                   tail_reg;
    logic                   tail_next;
    logic [MAX_COLUMNS-1:0] upper_reg;
    logic [MAX_COLUMNS-1:0] upper_next;
    logic [MAX_COLUMNS-1:0] middle_reg;
    logic [MAX_COLUMNS-1:0] middle_next;
    logic [MAX_COLUMNS-1:0] msuper_reg;
    logic [MAX_COLUMNS-1:0] msuper_next;

    // Output register.
    logic             out_valid_reg;
    logic             out_valid_next;
    lrs_pkg::row_t    next_alive_reg;
    lrs_pkg::row_t    next_super_reg;
    lrs_pkg::row_t    corrupt_reg;
    logic             grid_done_reg;

    logic [MAX_COLUMNS-1:0] col_mask;
    logic [MAX_COLUMNS-1:0] in_alive_m;
    logic [MAX_COLUMNS-1:0] in_super_m;
    logic [MAX_COLUMNS-1:0] sel_up;
    logic [MAX_COLUMNS-1:0] sel_mid;
    logic [MAX_COLUMNS-1:0] sel_sup;
    logic [MAX_COLUMNS-1:0] sel_low;
    logic                   sel_done;
    logic [MAX_COLUMNS-1:0] rule_alive;
    logic [MAX_COLUMNS-1:0] rule_super;
    logic [MAX_COLUMNS-1:0] rule_corrupt;
    logic                   emit_needed;
    logic                   out_ready;
    logic                   step_go;
    logic                   consume;

    // Columns at or beyond the active count are outside the grid. A count of
    // zero still keeps column zero; lanes stop at MAX_COLUMNS.
    for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_mask
        assign col_mask[c] = (c == 0)
                           || (lrs_pkg::COLCNT_W'(c) < active_columns_reg);
    end

    assign in_alive_m = alive_reg[MAX_COLUMNS-1:0] & col_mask;
    assign in_super_m = super_reg[MAX_COLUMNS-1:0] & col_mask;

    // A row that only fills an empty window produces nothing.
    assign emit_needed = in_valid_reg && (held_reg || final_reg);
    assign out_ready   = !out_valid_reg || !out_stall;
    assign step_go     = in_valid_reg && (!emit_needed || out_ready);
    // A bottom row closing a running window takes a second step for itself.
    assign consume     = step_go && !(held_reg && !tail_reg && final_reg);
    assign in_stall    = in_valid_reg && !consume;

    // Pick the three rows for the rule and update the window.
    always_comb
    begin
        sel_up      = '0;
        sel_mid     = in_alive_m;
        sel_sup     = in_super_m;
        sel_low     = '0;
        sel_done    = 1'b1;
        held_next   = held_reg;
        tail_next   = tail_reg;
        upper_next  = upper_reg;
        middle_next = middle_reg;
        msuper_next = msuper_reg;
        if (tail_reg)
        begin
            // Second result of a bottom row: the row below is dead.
            sel_up   = upper_reg & col_mask;
            sel_mid  = middle_reg & col_mask;
            sel_sup  = msuper_reg & col_mask;
        end
        else if (held_reg)
        begin
            sel_up   = upper_reg & col_mask;
            sel_mid  = middle_reg & col_mask;
            sel_sup  = msuper_reg & col_mask;
            sel_low  = in_alive_m;
            sel_done = 1'b0;
        end

        if (step_go)
        begin
            if (tail_reg || (!held_reg && final_reg))
            begin
                held_next   = 1'b0;
                tail_next   = 1'b0;
                upper_next  = '0;
                middle_next = '0;
                msuper_next = '0;
            end
            else
            begin
                held_next   = 1'b1;
                tail_next   = held_reg && final_reg;
                upper_next  = held_reg ? middle_reg : '0;
                middle_next = in_alive_m;
                msuper_next = in_super_m;
            end
        end
    end

    lrs_rule #(
        .COLS (MAX_COLUMNS)
    ) u_rule (
        .up        (sel_up),
        .mid       (sel_mid),
        .sup       (sel_sup),
        .low       (sel_low),
        .nxt_alive (rule_alive),
        .nxt_super (rule_super),
        .corrupt   (rule_corrupt)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_go && emit_needed)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_columns_reg <= lrs_pkg::COLCNT_RESET;
            in_valid_reg       <= 1'b0;
            held_reg           <= 1'b0;
            tail_reg           <= 1'b0;
            upper_reg          <= '0;
            middle_reg         <= '0;
            msuper_reg         <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                active_columns_reg <= cfg_write_data;
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            held_reg      <= held_next;
            tail_reg      <= tail_next;
            upper_reg     <= upper_next;
            middle_reg    <= middle_next;
            msuper_reg    <= msuper_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers. A birth just past the active width is outside the
    // grid, so the alive row is masked once more before it is stored.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            alive_reg <= alive_row;
            super_reg <= super_row;
            final_reg <= final_row;
        end
        if (step_go && emit_needed)
        begin
            next_alive_reg <= lrs_pkg::ROW_W'(rule_alive & col_mask);
            next_super_reg <= lrs_pkg::ROW_W'(rule_super);
            corrupt_reg    <= lrs_pkg::ROW_W'(rule_corrupt);
            grid_done_reg  <= sel_done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_alive   = next_alive_reg;
    assign next_super   = next_super_reg;
    assign corrupt_mask = corrupt_reg;
    assign grid_done    = grid_done_reg;

    // The second step of a bottom row only happens inside a running window.
    a_tail_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg |-> (held_reg && in_valid_reg && final_reg))
        else $error("tail step without a running window");

    // The input register only stalls while it holds a row.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled while empty");

    // A finished bottom row leaves the window empty.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && final_reg) |=> (!held_reg && !tail_reg))
        else $error("window not cleared after bottom row");

    // A result held back by the sink is not dropped.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");

    // A result is only written when the output register can take it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && emit_needed) |-> out_ready)
        else $error("result register overwritten");

endmodule
